// File: rtl/core/pdtd_pkg.sv
// pdtd_pkg: types, codes and the control store of the PWM duty temperature decoder.
// No dependencies; used by pwm_duty_temperature_decoder_core.
package pdtd_pkg;

  localparam int ClkW   = 27;  // timer clock register and frequency result
  localparam int CoefW  = 16;  // polynomial coefficients and temperature
  localparam int CapW   = 16;  // captured period and pulse
  localparam int UpcW   = 4;   // control store address
  localparam int LoopW  = 5;   // loop counter, holds the longest division
  localparam int AccW   = 50;  // polynomial accumulator, signed
  localparam int CfgIdxW = 2;

  typedef logic [UpcW-1:0]  upc_t;
  typedef logic [LoopW-1:0] loop_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV,
    OP_SAVE_FREQ,
    OP_SAVE_DUTY,
    OP_SETUP_MEAN,
    OP_SETUP_MUL1,
    OP_MUL,
    OP_SETUP_MUL2,
    OP_SAT,
    OP_OUT
  } op_t;

  // sequencer conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_WAIT_IN,
    C_LOOP,
    C_BLOCK,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // entry points
  localparam upc_t UPC_IDLE = 4'd0;
  localparam upc_t UPC_OUT  = 4'd11;

  // loop lengths, counted down to zero
  localparam loop_t DIV_FREQ_LAST = loop_t'(ClkW - 1);
  localparam loop_t DIV_DUTY_LAST = loop_t'(CapW - 1);
  localparam loop_t MUL_LAST      = loop_t'(CapW - 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_TIMER_CLOCK = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SQUARE_COEF = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LINEAR_COEF = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET      = 2'd3;

  // register reset values
  localparam logic [ClkW-1:0]         TIMER_CLOCK_RST = 27'd24000000;
  localparam logic signed [CoefW-1:0] SQUARE_COEF_RST = -16'sd143;
  localparam logic signed [CoefW-1:0] LINEAR_COEF_RST = 16'sd21456;
  localparam logic signed [CoefW-1:0] OFFSET_RST      = -16'sd6860;

  // control store
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    begin
      unique case (pc)
        4'd0:    w = '{OP_ACCEPT,     C_WAIT_IN,  UPC_OUT};
        4'd1:    w = '{OP_DIV,        C_LOOP,     UPC_IDLE};
        4'd2:    w = '{OP_SAVE_FREQ,  C_NEXT,     UPC_IDLE};
        4'd3:    w = '{OP_DIV,        C_LOOP,     UPC_IDLE};
        4'd4:    w = '{OP_SAVE_DUTY,  C_BLOCK,    UPC_OUT};
        4'd5:    w = '{OP_SETUP_MEAN, C_NEXT,     UPC_IDLE};
        4'd6:    w = '{OP_SETUP_MUL1, C_NEXT,     UPC_IDLE};
        4'd7:    w = '{OP_MUL,        C_LOOP,     UPC_IDLE};
        4'd8:    w = '{OP_SETUP_MUL2, C_NEXT,     UPC_IDLE};
        4'd9:    w = '{OP_MUL,        C_LOOP,     UPC_IDLE};
        4'd10:   w = '{OP_SAT,        C_NEXT,     UPC_IDLE};
        4'd11:   w = '{OP_OUT,        C_WAIT_OUT, UPC_IDLE};
        default: w = '{OP_NOP,        C_GOTO,     UPC_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

// File: rtl/core/pwm_duty_temperature_decoder_core.sv
// pwm_duty_temperature_decoder_core: microcoded PWM capture decoder, top level.
// Depends on pdtd_pkg (control store, codes, reset values).
//
// Usage
//   Config: plain write port (cfg_we, cfg_index, cfg_wdata). Write only while idle.
//   Input beat: in_period_count / in_pulse_count on in_valid; in_stall is high
//     whenever the sequencer is busy, so one capture is in flight at a time.
//   Output beat: one per input beat - frequency, Q0.16 duty, held temperature,
//     block-complete and zero-period flags; out_valid held until !out_stall.
// Sequencing
//   A shared restoring divider (one bit per cycle) and a shift-add multiplier
//   (one bit of the mean per cycle) are driven by a 12-word control store.
//   Zero period: the accept step goes straight to the output step. Normal beat:
//   accept, frequency divide, save, duty divide, save and output steps. A beat
//   that closes an averaging block adds the mean (reciprocal multiply), two
//   multiplies with their set-up steps and the saturation step, whatever AVG_COUNT is.
//   The output register frees the core: the next beat is taken while a result
//   still waits, but a second result stalls the sequencer at its output step.
// Reset
//   Synchronous, active low: registers back to their defaults, running sum,
//   sample count and held temperature cleared, no result pending.
module pwm_duty_temperature_decoder_core #(
  parameter int AVG_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [pdtd_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [pdtd_pkg::ClkW-1:0]          cfg_wdata,
  // input beats
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pdtd_pkg::CapW-1:0]          in_period_count,
  input  logic [pdtd_pkg::CapW-1:0]          in_pulse_count,
  // result beats
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pdtd_pkg::ClkW-1:0]          out_frequency_hz,
  output logic [pdtd_pkg::CapW-1:0]          out_duty_fraction,
  output logic signed [pdtd_pkg::CoefW-1:0]  out_temperature_centi,
  output logic                               out_temp_updated,
  output logic                               out_period_error
);

  localparam int CntW       = $clog2(AVG_COUNT);
  localparam int SumW       = pdtd_pkg::CapW + CntW;   // sum of a block never wraps
  // floor(sum / AVG_COUNT) = floor(sum * RecipMul / 2^RecipShift) for any SumW-bit sum
  localparam int RecipShift = SumW + CntW;
  localparam logic [SumW:0] RecipMul = (SumW+1)'(((64'd1 << RecipShift)
                                       + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));

  // configuration registers
  logic [pdtd_pkg::ClkW-1:0]         clk_hz_r;
  logic signed [pdtd_pkg::CoefW-1:0] coef_a_r, coef_b_r, coef_c_r;

  // sequencer
  pdtd_pkg::upc_t   pc_r, pc_nxt;
  pdtd_pkg::uword_t uw;
  pdtd_pkg::loop_t  lc_r, lc_nxt;

  // datapath
  logic [pdtd_pkg::CapW-1:0]         period_r, period_nxt;
  logic [pdtd_pkg::CapW-1:0]         pulse_r, pulse_nxt;
  logic [pdtd_pkg::CapW-1:0]         rem_r, rem_nxt;
  logic [pdtd_pkg::ClkW-1:0]         quo_r, quo_nxt;
  logic [pdtd_pkg::CapW-1:0]         dsr_r, dsr_nxt;
  logic signed [pdtd_pkg::AccW-1:0]  acc_r, acc_nxt;
  logic signed [pdtd_pkg::AccW-1:0]  mcand_r, mcand_nxt;
  logic [pdtd_pkg::CapW-1:0]         mul_r, mul_nxt;
  logic [pdtd_pkg::ClkW-1:0]         freq_r, freq_nxt;
  logic [pdtd_pkg::CapW-1:0]         duty_r, duty_nxt;
  logic                              upd_r, upd_nxt;
  logic                              err_r, err_nxt;

  // block state
  logic [SumW-1:0]                   sum_r, sum_nxt;
  logic [CntW-1:0]                   cnt_r, cnt_nxt;
  logic signed [pdtd_pkg::CoefW-1:0] temp_r, temp_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic [pdtd_pkg::ClkW-1:0]         out_freq_r;
  logic [pdtd_pkg::CapW-1:0]         out_duty_r;
  logic signed [pdtd_pkg::CoefW-1:0] out_temp_r;
  logic                              out_upd_r, out_err_r;

  logic                              in_acc, out_free;
  logic [pdtd_pkg::CapW:0]           div_shl;
  logic [pdtd_pkg::CapW+1:0]         div_diff;
  logic                              div_qbit;
  logic [pdtd_pkg::CapW-1:0]         div_rem;
  logic [pdtd_pkg::CapW-1:0]         duty_val;
  logic [CntW:0]                     cnt_inc;
  logic                              blk_done;
  logic [SumW-1:0]                   sum_add;
  logic [2*SumW:0]                   mean_prod;
  logic [pdtd_pkg::CapW-1:0]         mean_val;
  logic signed [pdtd_pkg::AccW-1:0]  mul_sum;
  logic signed [pdtd_pkg::AccW-pdtd_pkg::ClkW-6:0] poly_hi; // acc bits 49..32
  logic signed [pdtd_pkg::CoefW-1:0] poly_sat;

  assign uw       = pdtd_pkg::ucode(pc_r);
  assign in_stall = (uw.op != pdtd_pkg::OP_ACCEPT);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // restoring divider step: one quotient bit per cycle
  assign div_shl  = {rem_r, quo_r[pdtd_pkg::ClkW-1]};
  assign div_diff = {1'b0, div_shl} - {2'b00, dsr_r};
  assign div_qbit = !div_diff[pdtd_pkg::CapW+1];
  assign div_rem  = div_qbit ? div_diff[pdtd_pkg::CapW-1:0] : div_shl[pdtd_pkg::CapW-1:0];

  // duty saturates when the pulse is not shorter than the period
  assign duty_val = (pulse_r >= period_r) ? '1 : quo_r[pdtd_pkg::CapW-1:0];
  assign cnt_inc  = {1'b0, cnt_r} + (CntW+1)'(1);
  assign blk_done = (cnt_inc == (CntW+1)'(AVG_COUNT));
  assign sum_add  = sum_r + SumW'(duty_val);

  // block mean by constant reciprocal, exact over the whole sum range
  assign mean_prod = (2*SumW+1)'(sum_r) * (2*SumW+1)'(RecipMul);
  assign mean_val  = mean_prod[RecipShift +: pdtd_pkg::CapW];

  // shift-add multiplier step
  assign mul_sum  = acc_r + (mul_r[0] ? mcand_r : '0);

  // floor(acc / 2^32), clipped to 16-bit signed
  assign poly_hi  = acc_r[pdtd_pkg::AccW-1:32];
  always_comb begin
    priority if (poly_hi > 18'sd32767) begin
      poly_sat = 16'sh7FFF;
    end else if (poly_hi < -18'sd32768) begin
      poly_sat = 16'sh8000;
    end else begin
      poly_sat = poly_hi[pdtd_pkg::CoefW-1:0];
    end
  end

  // sequencer
  always_comb begin
    unique case (uw.cond)
      pdtd_pkg::C_NEXT:     pc_nxt = pc_r + pdtd_pkg::upc_t'(1);
      pdtd_pkg::C_GOTO:     pc_nxt = uw.target;
      pdtd_pkg::C_WAIT_IN: begin
        priority if (!in_acc) begin
          pc_nxt = pc_r;
        end else if (in_period_count == '0) begin
          pc_nxt = uw.target;
        end else begin
          pc_nxt = pc_r + pdtd_pkg::upc_t'(1);
        end
      end
      pdtd_pkg::C_LOOP:     pc_nxt = (lc_r != '0) ? pc_r : pc_r + pdtd_pkg::upc_t'(1);
      pdtd_pkg::C_BLOCK:    pc_nxt = blk_done ? pc_r + pdtd_pkg::upc_t'(1) : uw.target;
      pdtd_pkg::C_WAIT_OUT: pc_nxt = out_free ? uw.target : pc_r;
      default:              pc_nxt = pdtd_pkg::UPC_IDLE;
    endcase
  end

  // datapath controlled by the current control word
  always_comb begin
    lc_nxt        = lc_r;
    period_nxt    = period_r;
    pulse_nxt     = pulse_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dsr_nxt       = dsr_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mul_nxt       = mul_r;
    freq_nxt      = freq_r;
    duty_nxt      = duty_r;
    upd_nxt       = upd_r;
    err_nxt       = err_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    temp_nxt      = temp_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (uw.op)
      pdtd_pkg::OP_ACCEPT: begin
        if (in_acc) begin
          period_nxt = in_period_count;
          pulse_nxt  = in_pulse_count;
          rem_nxt    = '0;
          quo_nxt    = clk_hz_r;
          dsr_nxt    = in_period_count;
          lc_nxt     = pdtd_pkg::DIV_FREQ_LAST;
          freq_nxt   = '0;
          duty_nxt   = '0;
          upd_nxt    = 1'b0;
          err_nxt    = (in_period_count == '0);
        end
      end
      pdtd_pkg::OP_DIV: begin
        rem_nxt = div_rem;
        quo_nxt = {quo_r[pdtd_pkg::ClkW-2:0], div_qbit};
        lc_nxt  = lc_r - pdtd_pkg::loop_t'(1);
      end
      pdtd_pkg::OP_SAVE_FREQ: begin
        freq_nxt = quo_r;
        rem_nxt  = pulse_r;   // pulse < period keeps the remainder invariant
        quo_nxt  = '0;
        lc_nxt   = pdtd_pkg::DIV_DUTY_LAST;
      end
      pdtd_pkg::OP_SAVE_DUTY: begin
        duty_nxt = duty_val;
        sum_nxt  = sum_add;
        if (blk_done) begin
          cnt_nxt = '0;
          upd_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_inc[CntW-1:0];
        end
      end
      pdtd_pkg::OP_SETUP_MEAN: begin
        // mean lands in the low quotient bits, where the multiplier picks it up
        quo_nxt = {{(pdtd_pkg::ClkW-pdtd_pkg::CapW){1'b0}}, mean_val};
        sum_nxt = '0;
      end
      pdtd_pkg::OP_SETUP_MUL1: begin
        // acc = b * 2^16, then acc += a * mean
        mul_nxt   = quo_r[pdtd_pkg::CapW-1:0];
        acc_nxt   = {{18{coef_b_r[15]}}, coef_b_r, 16'h0000};
        mcand_nxt = {{34{coef_a_r[15]}}, coef_a_r};
        lc_nxt    = pdtd_pkg::MUL_LAST;
      end
      pdtd_pkg::OP_MUL: begin
        acc_nxt   = mul_sum;
        mcand_nxt = mcand_r <<< 1;
        mul_nxt   = {mul_r[0], mul_r[pdtd_pkg::CapW-1:1]};  // rotate: mean is back in place when the loop ends
        lc_nxt    = lc_r - pdtd_pkg::loop_t'(1);
      end
      pdtd_pkg::OP_SETUP_MUL2: begin
        // acc = c * 2^32, then acc += (a*mean + b*2^16) * mean
        mcand_nxt = acc_r;
        acc_nxt   = {{2{coef_c_r[15]}}, coef_c_r, 32'h0000_0000};
        lc_nxt    = pdtd_pkg::MUL_LAST;
      end
      pdtd_pkg::OP_SAT: begin
        temp_nxt = poly_sat;
      end
      pdtd_pkg::OP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= pdtd_pkg::UPC_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      temp_r      <= '0;
      clk_hz_r    <= pdtd_pkg::TIMER_CLOCK_RST;
      coef_a_r    <= pdtd_pkg::SQUARE_COEF_RST;
      coef_b_r    <= pdtd_pkg::LINEAR_COEF_RST;
      coef_c_r    <= pdtd_pkg::OFFSET_RST;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      temp_r      <= temp_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pdtd_pkg::REG_TIMER_CLOCK: clk_hz_r <= cfg_wdata;
          pdtd_pkg::REG_SQUARE_COEF: coef_a_r <= cfg_wdata[pdtd_pkg::CoefW-1:0];
          pdtd_pkg::REG_LINEAR_COEF: coef_b_r <= cfg_wdata[pdtd_pkg::CoefW-1:0];
          pdtd_pkg::REG_OFFSET:      coef_c_r <= cfg_wdata[pdtd_pkg::CoefW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lc_r     <= lc_nxt;
    period_r <= period_nxt;
    pulse_r  <= pulse_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dsr_r    <= dsr_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mul_r    <= mul_nxt;
    freq_r   <= freq_nxt;
    duty_r   <= duty_nxt;
    upd_r    <= upd_nxt;
    err_r    <= err_nxt;
    if (uw.op == pdtd_pkg::OP_OUT && out_free) begin
      out_freq_r <= freq_r;
      out_duty_r <= duty_r;
      out_temp_r <= temp_r;
      out_upd_r  <= upd_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_frequency_hz      = out_freq_r;
  assign out_duty_fraction     = out_duty_r;
  assign out_temperature_centi = out_temp_r;
  assign out_temp_updated      = out_upd_r;
  assign out_period_error      = out_err_r;

  // checks
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period_error |->
      out_frequency_hz == '0 && out_duty_fraction == '0 && !out_temp_updated)
    else $error("rejected beat carries non-zero results");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} < (CntW+1)'(AVG_COUNT))
    else $error("sample count beyond block length");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_period_count == '0 |=> pc_r == pdtd_pkg::UPC_OUT)
    else $error("zero period did not skip to output step");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(uw.op == pdtd_pkg::OP_OUT))
    else $error("result raised outside the output step");

endmodule
